FILE: hw/rtl/depth_jet_colormap_overlay_core_assert.svh
// Assertion macros shared by the colormap pipeline modules.
`ifndef DEPTH_JET_COLORMAP_OVERLAY_CORE_ASSERT_SVH
`define DEPTH_JET_COLORMAP_OVERLAY_CORE_ASSERT_SVH

// The consequence must hold in the same cycle as the trigger.
`define DJC_ASSERT_NOW(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the trigger.
`define DJC_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/djc_pkg.sv
// Shared constants and types of the depth colormap overlay pipeline.
package djc_pkg;

  localparam int DISPARITY_BITS_DEF = 16;
  localparam int FOCAL_BITS         = 32;
  localparam int DEPTH_BITS         = 16;
  localparam int UPPER_BITS         = DEPTH_BITS + 1;
  localparam int GRAY_BITS          = 8;
  localparam int COLOR_BITS         = 8;
  localparam int CFG_DATA_BITS      = 32;
  localparam int CFG_ADDR_BITS      = 4;
  localparam int REG_IDX_BITS       = 2;

  localparam logic [REG_IDX_BITS-1:0] REG_FOCAL_BASELINE = REG_IDX_BITS'(0);
  localparam logic [REG_IDX_BITS-1:0] REG_MIN_DEPTH      = REG_IDX_BITS'(1);
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_DEPTH      = REG_IDX_BITS'(2);
  localparam logic [REG_IDX_BITS-1:0] REG_OVERLAY_MODE   = REG_IDX_BITS'(3);

  localparam logic [FOCAL_BITS-1:0] FOCAL_BASELINE_RESET = FOCAL_BITS'(1000000);
  localparam logic [DEPTH_BITS-1:0] MIN_DEPTH_RESET      = DEPTH_BITS'(0);
  localparam logic [DEPTH_BITS-1:0] MAX_DEPTH_RESET      = DEPTH_BITS'(10000);
  localparam logic                  OVERLAY_MODE_RESET   = 1'b1;

  localparam logic [COLOR_BITS-1:0] COLOR_MAX = '1;

  // Colormap segments, named after the channel that carries the ramp.
  typedef logic [1:0] seg_t;
  localparam seg_t SEG_RISE_G = 2'd0;
  localparam seg_t SEG_FALL_B = 2'd1;
  localparam seg_t SEG_RISE_R = 2'd2;
  localparam seg_t SEG_FALL_G = 2'd3;

  typedef struct packed {
    logic [FOCAL_BITS-1:0] focal_baseline;
    logic [DEPTH_BITS-1:0] min_depth;
    logic [DEPTH_BITS-1:0] span;
    logic [UPPER_BITS-1:0] upper;
    logic                  overlay_mode;
  } cfg_t;

  typedef struct packed {
    logic                  invalid;
    logic [GRAY_BITS-1:0]  gray;
    logic [DEPTH_BITS-1:0] n;
  } depth_t;

  typedef struct packed {
    logic                  invalid;
    logic [GRAY_BITS-1:0]  gray;
    seg_t                  seg;
    logic [COLOR_BITS-1:0] level;
  } color_t;

endpackage

FILE: hw/rtl/djc_in_if.sv
// Pixel input channel: disparity and gray value with valid/ready.
interface djc_in_if #(
  parameter int DISPARITY_BITS = djc_pkg::DISPARITY_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [DISPARITY_BITS-1:0] disparity;
  logic [djc_pkg::GRAY_BITS-1:0]    gray;

  modport source (output valid, disparity, gray, input ready);
  modport sink (input valid, disparity, gray, output ready);
endinterface

FILE: hw/rtl/djc_out_if.sv
// Pixel output channel: BGR bytes with valid/ready.
interface djc_out_if;
  logic                           valid;
  logic                           ready;
  logic [djc_pkg::COLOR_BITS-1:0] blue;
  logic [djc_pkg::COLOR_BITS-1:0] green;
  logic [djc_pkg::COLOR_BITS-1:0] red;

  modport source (output valid, blue, green, red, input ready);
  modport sink (input valid, blue, green, red, output ready);
endinterface

FILE: hw/rtl/depth_jet_colormap_overlay_core.sv
// Top level of the depth colormap overlay: registers, divider, ramp and blend.
//
//  channel   direction  handshake           payload
//  in_ch     sink       valid / ready       disparity, gray
//  out_ch    source     valid / ready       blue, green, red
//  cfg (APB) slave      psel+penable, pready  paddr, pwdata, prdata
//
// One pixel can be accepted every clock unless every stage holds one and the output
// is stalled; its result reaches the output register through 44 register stages:
// 32 depth quotient stages and a clamp stage, the segment and numerator stages,
// eight ramp quotient stages and the output register.
// Reset clears all stage valid bits and loads the register reset values.
// A stalled output holds its pixel; requests keep entering until all 44 stages hold one.
module depth_jet_colormap_overlay_core #(
  parameter int DISPARITY_BITS = djc_pkg::DISPARITY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  djc_in_if.sink                            in_ch,
  djc_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [djc_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [djc_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [djc_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  djc_pkg::cfg_t   cfg;
  logic            dv_valid;
  logic            dv_ready;
  djc_pkg::depth_t dv_depth;
  logic            cl_valid;
  logic            cl_ready;
  djc_pkg::color_t cl_color;

  djc_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  djc_depth_div #(
    .DISPARITY_BITS (DISPARITY_BITS)
  ) u_depth (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_depth (dv_depth)
  );

  djc_ramp_div u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_depth  (dv_depth),
    .out_valid (cl_valid),
    .out_ready (cl_ready),
    .out_color (cl_color)
  );

  djc_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (cl_valid),
    .in_ready (cl_ready),
    .in_color (cl_color),
    .out_ch   (out_ch)
  );

endmodule

FILE: hw/rtl/djc_cfg_regs.sv
// APB register file holding the depth range, focal scale and blend mode.
module djc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [djc_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [djc_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [djc_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output djc_pkg::cfg_t                       cfg
);

  logic [djc_pkg::FOCAL_BITS-1:0]   focal_r;
  logic [djc_pkg::DEPTH_BITS-1:0]   min_r;
  logic [djc_pkg::DEPTH_BITS-1:0]   max_r;
  logic                             mode_r;
  logic [djc_pkg::REG_IDX_BITS-1:0] idx;
  logic                             wr;

  assign pready = 1'b1;
  assign idx    = paddr[djc_pkg::CFG_ADDR_BITS-1:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= djc_pkg::FOCAL_BASELINE_RESET;
      min_r   <= djc_pkg::MIN_DEPTH_RESET;
      max_r   <= djc_pkg::MAX_DEPTH_RESET;
      mode_r  <= djc_pkg::OVERLAY_MODE_RESET;
    end else if (wr) begin
      case (idx)
        djc_pkg::REG_FOCAL_BASELINE: focal_r <= pwdata[djc_pkg::FOCAL_BITS-1:0];
        djc_pkg::REG_MIN_DEPTH:      min_r   <= pwdata[djc_pkg::DEPTH_BITS-1:0];
        djc_pkg::REG_MAX_DEPTH:      max_r   <= pwdata[djc_pkg::DEPTH_BITS-1:0];
        djc_pkg::REG_OVERLAY_MODE:   mode_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      djc_pkg::REG_FOCAL_BASELINE: prdata = djc_pkg::CFG_DATA_BITS'(focal_r);
      djc_pkg::REG_MIN_DEPTH:      prdata = djc_pkg::CFG_DATA_BITS'(min_r);
      djc_pkg::REG_MAX_DEPTH:      prdata = djc_pkg::CFG_DATA_BITS'(max_r);
      djc_pkg::REG_OVERLAY_MODE:   prdata = djc_pkg::CFG_DATA_BITS'(mode_r);
      default:                     prdata = '0;
    endcase
  end

  // An empty or inverted range is treated as a span of one millimetre.
  always_comb begin
    cfg.focal_baseline = focal_r;
    cfg.min_depth      = min_r;
    cfg.span           = (max_r > min_r) ? (max_r - min_r) : djc_pkg::DEPTH_BITS'(1);
    cfg.upper          = djc_pkg::UPPER_BITS'(min_r) + djc_pkg::UPPER_BITS'(cfg.span);
    cfg.overlay_mode   = mode_r;
  end

endmodule

FILE: hw/rtl/djc_depth_div.sv
// Pipelined restoring divider for depth, one quotient bit per stage, then clamping.
`include "depth_jet_colormap_overlay_core_assert.svh"

module djc_depth_div #(
  parameter int DISPARITY_BITS = djc_pkg::DISPARITY_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  djc_pkg::cfg_t   cfg,
  djc_in_if.sink          in_ch,
  output logic            out_valid,
  input  logic            out_ready,
  output djc_pkg::depth_t out_depth
);

  localparam int QB = djc_pkg::FOCAL_BITS;
  localparam int DB = DISPARITY_BITS;
  localparam int UB = djc_pkg::UPPER_BITS;
  localparam int S  = QB + 1;

  typedef struct packed {
    logic                          neg;
    logic                          zero;
    logic [djc_pkg::GRAY_BITS-1:0] gray;
  } tag_t;

  logic [S-1:0]  v_r;
  logic [S-1:0]  v_nxt;
  logic [S-1:0]  rdy;

  logic [DB-2:0] rem_r   [QB];
  logic [DB-2:0] rem_nxt [QB];
  logic [DB-2:0] dvs_r   [QB];
  logic [DB-2:0] dvs_nxt [QB];
  logic [QB-1:0] quo_r   [QB];
  logic [QB-1:0] quo_nxt [QB];
  tag_t          tag_r   [QB];
  tag_t          tag_nxt [QB];
  tag_t          tag_in;

  djc_pkg::depth_t depth_r;
  djc_pkg::depth_t depth_nxt;

  // A stage may load when it is empty or when every stage after it moves on.
  always_comb begin
    logic [S-1:0] below;
    for (int k = 0; k < S; k++) begin
      below  = (S'(1) << k) - S'(1);
      rdy[k] = out_ready || !(&(v_r | below));
    end
  end

  assign in_ch.ready = rdy[0];
  assign v_nxt = (rdy[S-1:0] & {v_r[S-2:0], in_ch.valid}) | (~rdy[S-1:0] & v_r);

  assign tag_in.neg  = in_ch.disparity[DB-1];
  assign tag_in.zero = (in_ch.disparity == '0);
  assign tag_in.gray = in_ch.gray;

  // Each stage brings down the next dividend bit and tries one subtraction.
  always_comb begin
    logic [DB-2:0] rem_src;
    logic [DB-2:0] dvs_src;
    logic [QB-1:0] quo_src;
    logic [DB-1:0] trial;
    logic [DB-1:0] diff;
    logic          take;
    for (int k = 0; k < QB; k++) begin
      rem_src    = (k == 0) ? '0 : rem_r[(k == 0) ? 0 : k - 1];
      dvs_src    = (k == 0) ? in_ch.disparity[DB-2:0] : dvs_r[(k == 0) ? 0 : k - 1];
      quo_src    = (k == 0) ? '0 : quo_r[(k == 0) ? 0 : k - 1];
      tag_nxt[k] = (k == 0) ? tag_in : tag_r[(k == 0) ? 0 : k - 1];
      trial      = {rem_src, cfg.focal_baseline[QB-1-k]};
      diff       = trial - {1'b0, dvs_src};
      take       = (trial >= {1'b0, dvs_src});
      rem_nxt[k] = take ? diff[DB-2:0] : trial[DB-2:0];
      dvs_nxt[k] = dvs_src;
      quo_nxt[k] = {quo_src[QB-2:0], take};
    end
  end

  // Zero disparity saturates to the far end; the quotient is clamped to the range.
  always_comb begin
    logic [QB-1:0] q;
    logic          lo;
    logic          hi;
    logic [UB-1:0] off;
    q   = quo_r[QB-1];
    lo  = (q < QB'(cfg.min_depth));
    hi  = (q > QB'(cfg.upper));
    off = q[UB-1:0] - UB'(cfg.min_depth);
    depth_nxt.invalid = tag_r[QB-1].neg;
    depth_nxt.gray    = tag_r[QB-1].gray;
    if (tag_r[QB-1].zero || hi) begin
      depth_nxt.n = cfg.span;
    end else if (lo) begin
      depth_nxt.n = '0;
    end else begin
      depth_nxt.n = off[djc_pkg::DEPTH_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QB; k++) begin
      if (rdy[k]) begin
        rem_r[k] <= rem_nxt[k];
        dvs_r[k] <= dvs_nxt[k];
        quo_r[k] <= quo_nxt[k];
        tag_r[k] <= tag_nxt[k];
      end
    end
    if (rdy[QB]) begin
      depth_r <= depth_nxt;
    end
  end

  assign out_valid = v_r[S-1];
  assign out_depth = depth_r;

  `DJC_ASSERT_NEXT(a_depth_enter, in_ch.valid && in_ch.ready, v_r[0], "accepted request missing from the first divider stage")
  `DJC_ASSERT_NEXT(a_depth_hold, v_r[S-1] && !out_ready, v_r[S-1] && $stable(depth_r), "stalled depth result was lost or changed")

endmodule

FILE: hw/rtl/djc_ramp_div.sv
// Colormap segment selection and pipelined division of the ramp level by the span.
`include "depth_jet_colormap_overlay_core_assert.svh"

module djc_ramp_div (
  input  logic            clk,
  input  logic            rst_n,
  input  djc_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  djc_pkg::depth_t in_depth,
  output logic            out_valid,
  input  logic            out_ready,
  output djc_pkg::color_t out_color
);

  localparam int DB = djc_pkg::DEPTH_BITS;
  localparam int CB = djc_pkg::COLOR_BITS;
  localparam int NB = DB + CB;
  localparam int RB = DB + 2;
  localparam int S  = CB + 2;

  typedef struct packed {
    logic                          invalid;
    logic [djc_pkg::GRAY_BITS-1:0] gray;
    djc_pkg::seg_t                 seg;
  } tag_t;

  logic [S-1:0]  v_r;
  logic [S-1:0]  v_nxt;
  logic [S-1:0]  rdy;

  tag_t          tag_r   [S];
  tag_t          tag_nxt [S];
  logic [DB-1:0] m_r;
  logic [DB-1:0] m_nxt;
  logic [NB-1:0] num_r;
  logic [NB-1:0] num_nxt;
  logic [NB-1:0] rem_r   [CB];
  logic [NB-1:0] rem_nxt [CB];
  logic [CB-1:0] lvl_r   [CB];
  logic [CB-1:0] lvl_nxt [CB];

  always_comb begin
    logic [S-1:0] below;
    for (int k = 0; k < S; k++) begin
      below  = (S'(1) << k) - S'(1);
      rdy[k] = out_ready || !(&(v_r | below));
    end
  end

  assign in_ready = rdy[0];
  assign v_nxt = (rdy[S-1:0] & {v_r[S-2:0], in_valid}) | (~rdy[S-1:0] & v_r);

  // Quarter points of the span split the ramp into four segments; m is the distance
  // from the start of a rising segment or to the end of a falling one, scaled by four.
  always_comb begin
    logic [RB-1:0] n4;
    logic [RB-1:0] sp1;
    logic [RB-1:0] sp2;
    logic [RB-1:0] sp3;
    logic [RB-1:0] sp4;
    logic [RB-1:0] m0;
    n4  = {in_depth.n, 2'b00};
    sp1 = RB'(cfg.span);
    sp2 = sp1 << 1;
    sp3 = sp1 + sp2;
    sp4 = sp1 << 2;
    tag_nxt[0].invalid = in_depth.invalid;
    tag_nxt[0].gray    = in_depth.gray;
    if (n4 < sp1) begin
      tag_nxt[0].seg = djc_pkg::SEG_RISE_G;
      m0             = n4;
    end else if (n4 < sp2) begin
      tag_nxt[0].seg = djc_pkg::SEG_FALL_B;
      m0             = sp2 - n4;
    end else if (n4 < sp3) begin
      tag_nxt[0].seg = djc_pkg::SEG_RISE_R;
      m0             = n4 - sp2;
    end else begin
      tag_nxt[0].seg = djc_pkg::SEG_FALL_G;
      m0             = sp4 - n4;
    end
    m_nxt = m0[DB-1:0];
    for (int k = 1; k < S; k++) begin
      tag_nxt[k] = tag_r[k-1];
    end
  end

  assign num_nxt = {m_r, {CB{1'b0}}} - NB'(m_r);

  // The numerator stays below the span shifted by the quotient width, so each
  // stage settles one quotient bit against the span shifted into place.
  always_comb begin
    logic [NB-1:0] src;
    logic [CB-1:0] lsrc;
    logic [NB-1:0] dsh;
    logic          take;
    for (int k = 0; k < CB; k++) begin
      src        = (k == 0) ? num_r : rem_r[(k == 0) ? 0 : k - 1];
      lsrc       = (k == 0) ? '0 : lvl_r[(k == 0) ? 0 : k - 1];
      dsh        = NB'(cfg.span) << (CB - 1 - k);
      take       = (src >= dsh);
      rem_nxt[k] = take ? (src - dsh) : src;
      lvl_nxt[k] = {lsrc[CB-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < S; k++) begin
      if (rdy[k]) begin
        tag_r[k] <= tag_nxt[k];
      end
    end
    if (rdy[0]) begin
      m_r <= m_nxt;
    end
    if (rdy[1]) begin
      num_r <= num_nxt;
    end
    for (int k = 0; k < CB; k++) begin
      if (rdy[k+2]) begin
        rem_r[k] <= rem_nxt[k];
        lvl_r[k] <= lvl_nxt[k];
      end
    end
  end

  assign out_valid         = v_r[S-1];
  assign out_color.invalid = tag_r[S-1].invalid;
  assign out_color.gray    = tag_r[S-1].gray;
  assign out_color.seg     = tag_r[S-1].seg;
  assign out_color.level   = lvl_r[CB-1];

  `DJC_ASSERT_NEXT(a_ramp_enter, in_valid && in_ready, v_r[0], "accepted request missing from the segment stage")
  `DJC_ASSERT_NEXT(a_ramp_hold, v_r[S-1] && !out_ready, v_r[S-1] && $stable(out_color), "stalled ramp result was lost or changed")

endmodule

FILE: hw/rtl/djc_blend.sv
// Builds the BGR pixel, blends it over gray and holds it in the output register.
`include "depth_jet_colormap_overlay_core_assert.svh"

module djc_blend (
  input  logic            clk,
  input  logic            rst_n,
  input  djc_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  djc_pkg::color_t in_color,
  djc_out_if.source       out_ch
);

  localparam int CB = djc_pkg::COLOR_BITS;
  localparam int XB = CB + 3;
  localparam int PB = 24;
  localparam logic [PB-1:0] RECIP10 = PB'(6554);

  logic          valid_r;
  logic [CB-1:0] blue_r;
  logic [CB-1:0] green_r;
  logic [CB-1:0] red_r;
  logic [CB-1:0] blue_nxt;
  logic [CB-1:0] green_nxt;
  logic [CB-1:0] red_nxt;

  // Exact for every value below 16384, well above the largest sum used here.
  function automatic logic [CB-1:0] div10(input logic [XB-1:0] x);
    logic [PB-1:0] prod;
    prod = PB'(x) * RECIP10;
    return prod[PB-1:16];
  endfunction

  function automatic logic [CB-1:0] mix(input logic [CB-1:0] c, input logic [CB-1:0] g);
    logic [CB:0] sum;
    sum = {1'b0, div10(XB'(c) * XB'(6) + XB'(5))} + {1'b0, div10(XB'(g) * XB'(4) + XB'(5))};
    return (sum > {1'b0, djc_pkg::COLOR_MAX}) ? djc_pkg::COLOR_MAX : sum[CB-1:0];
  endfunction

  always_comb begin
    logic [CB-1:0] b;
    logic [CB-1:0] g;
    logic [CB-1:0] r;
    logic [CB-1:0] flat;
    case (in_color.seg)
      djc_pkg::SEG_RISE_G: begin
        b = djc_pkg::COLOR_MAX;
        g = in_color.level;
        r = '0;
      end
      djc_pkg::SEG_FALL_B: begin
        b = in_color.level;
        g = djc_pkg::COLOR_MAX;
        r = '0;
      end
      djc_pkg::SEG_RISE_R: begin
        b = '0;
        g = djc_pkg::COLOR_MAX;
        r = in_color.level;
      end
      djc_pkg::SEG_FALL_G: begin
        b = '0;
        g = in_color.level;
        r = djc_pkg::COLOR_MAX;
      end
      default: begin
        b = '0;
        g = '0;
        r = '0;
      end
    endcase
    flat = cfg.overlay_mode ? in_color.gray : djc_pkg::COLOR_MAX;
    if (in_color.invalid) begin
      blue_nxt  = flat;
      green_nxt = flat;
      red_nxt   = flat;
    end else if (cfg.overlay_mode) begin
      blue_nxt  = mix(b, in_color.gray);
      green_nxt = mix(g, in_color.gray);
      red_nxt   = mix(r, in_color.gray);
    end else begin
      blue_nxt  = b;
      green_nxt = g;
      red_nxt   = r;
    end
  end

  assign in_ready = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
      red_r   <= red_nxt;
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.blue  = blue_r;
  assign out_ch.green = green_r;
  assign out_ch.red   = red_r;

  `DJC_ASSERT_NOW(a_blend_stall, in_valid && !in_ready, out_ch.valid && !out_ch.ready, "output stage refused a request while free")

endmodule

FILE: verif/tb_depth_jet_colormap_overlay_core.sv
// Self-checking testbench for the depth colormap overlay core: random traffic and register settings.
module tb_depth_jet_colormap_overlay_core;

  localparam int DISP_W      = djc_pkg::DISPARITY_BITS_DEF;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 60;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [DISP_W-1:0]      disparity;
    logic [djc_pkg::GRAY_BITS-1:0] gray;
  } pixel_req_t;

  typedef struct packed {
    logic [djc_pkg::COLOR_BITS-1:0] blue;
    logic [djc_pkg::COLOR_BITS-1:0] green;
    logic [djc_pkg::COLOR_BITS-1:0] red;
  } bgr_t;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [djc_pkg::CFG_ADDR_BITS-1:0] paddr;
  logic [djc_pkg::CFG_DATA_BITS-1:0] pwdata;
  logic [djc_pkg::CFG_DATA_BITS-1:0] prdata;
  logic                              pready;

  djc_in_if #(.DISPARITY_BITS(DISP_W)) in_ch ();
  djc_out_if out_ch ();

  depth_jet_colormap_overlay_core #(.DISPARITY_BITS(DISP_W)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the block's registers.
  logic [djc_pkg::FOCAL_BITS-1:0] cfg_focal;
  logic [djc_pkg::DEPTH_BITS-1:0] cfg_min;
  logic [djc_pkg::DEPTH_BITS-1:0] cfg_max;
  logic                           cfg_overlay;

  pixel_req_t pending_pixels[$];
  bgr_t       predicted_bgr[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  gap_left;
  int  stall_left;
  bit  sender_no_gaps = 1'b0;
  bit  receiver_no_stalls = 1'b0;
  bit  long_hold_armed = 1'b0;
  bit  long_hold_taken;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned blend_over_gray(longint unsigned c, longint unsigned gv);
    longint unsigned s;
    s = (6 * c + 5) / 10 + (4 * gv + 5) / 10;
    return (s > 255) ? 255 : s;
  endfunction

  // Expected BGR pixel for one request under the current register values.
  function automatic bgr_t jet_pixel(logic signed [DISP_W-1:0] disp,
                                     logic [djc_pkg::GRAY_BITS-1:0] gray);
    longint unsigned lo, span, upper, depth, n4;
    longint unsigned b, g, r;
    bgr_t px;
    if (disp[DISP_W-1]) begin
      b = cfg_overlay ? gray : 255;
      g = b;
      r = b;
    end else begin
      lo = cfg_min;
      span = (cfg_max > cfg_min) ? cfg_max - cfg_min : 1;
      upper = lo + span;
      if (disp == 0) begin
        depth = upper;
      end else begin
        depth = cfg_focal / disp[DISP_W-2:0];
      end
      if (depth < lo) depth = lo;
      if (depth > upper) depth = upper;
      n4 = 4 * (depth - lo);
      if (n4 < span) begin
        b = 255;
        g = (255 * n4) / span;
        r = 0;
      end else if (n4 < 2 * span) begin
        b = (255 * (2 * span - n4)) / span;
        g = 255;
        r = 0;
      end else if (n4 < 3 * span) begin
        b = 0;
        g = 255;
        r = (255 * (n4 - 2 * span)) / span;
      end else begin
        b = 0;
        g = (255 * (4 * span - n4)) / span;
        r = 255;
      end
      if (cfg_overlay) begin
        b = blend_over_gray(b, gray);
        g = blend_over_gray(g, gray);
        r = blend_over_gray(r, gray);
      end
    end
    px.blue  = djc_pkg::COLOR_BITS'(b);
    px.green = djc_pkg::COLOR_BITS'(g);
    px.red   = djc_pkg::COLOR_BITS'(r);
    return px;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int draw_idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    $display("mismatch in %s: expected %0d, got %0d", what, want, got);
    error_count++;
  endtask

  // Request driver.
  always @(posedge clk) begin
    pixel_req_t nxt;
    bit offer;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      offer = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        predicted_bgr = {predicted_bgr, jet_pixel(in_ch.disparity, in_ch.gray)};
      end
      if (in_ch.valid && !in_ch.ready) begin
        offer = 1'b1;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_pixels.size() != 0) begin
        nxt = pending_pixels.pop_front();
        in_ch.disparity <= nxt.disparity;
        in_ch.gray <= nxt.gray;
        offer = 1'b1;
        gap_left <= sender_no_gaps ? 0 : draw_idle_len();
      end
      in_ch.valid <= offer;
    end
  end

  // Result back-pressure, including one long hold to fill the pipeline.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      long_hold_taken <= 1'b0;
    end else if (long_hold_armed && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      stall_left <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!receiver_no_stalls && $urandom_range(0, 3) == 0) begin
      stall_left <= draw_idle_len();
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    bgr_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_bgr.size() == 0) begin
        report_mismatch("pixel with no request pending", -1,
                        {out_ch.blue, out_ch.green, out_ch.red});
      end else begin
        want = predicted_bgr.pop_front();
        if (out_ch.blue !== want.blue) report_mismatch("blue", want.blue, out_ch.blue);
        if (out_ch.green !== want.green) report_mismatch("green", want.green, out_ch.green);
        if (out_ch.red !== want.red) report_mismatch("red", want.red, out_ch.red);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [djc_pkg::REG_IDX_BITS-1:0] idx,
                           logic [djc_pkg::CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      djc_pkg::REG_FOCAL_BASELINE: cfg_focal = value;
      djc_pkg::REG_MIN_DEPTH:      cfg_min = value[djc_pkg::DEPTH_BITS-1:0];
      djc_pkg::REG_MAX_DEPTH:      cfg_max = value[djc_pkg::DEPTH_BITS-1:0];
      djc_pkg::REG_OVERLAY_MODE:   cfg_overlay = value[0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] focal, logic [15:0] lo, logic [15:0] hi, bit overlay);
    write_reg(djc_pkg::REG_FOCAL_BASELINE, focal);
    write_reg(djc_pkg::REG_MIN_DEPTH, djc_pkg::CFG_DATA_BITS'(lo));
    write_reg(djc_pkg::REG_MAX_DEPTH, djc_pkg::CFG_DATA_BITS'(hi));
    write_reg(djc_pkg::REG_OVERLAY_MODE, djc_pkg::CFG_DATA_BITS'(overlay));
  endtask

  // Returns once every queued request has been taken and every pixel has come back.
  task automatic drain();
    while (pending_pixels.size() != 0 || in_ch.valid || predicted_bgr.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_pixel(int disp, int gray);
    pixel_req_t px;
    px.disparity = DISP_W'(disp);
    px.gray = djc_pkg::GRAY_BITS'(gray);
    pending_pixels = {pending_pixels, px};
  endtask

  // Edge values and one depth in each colormap segment under the reset registers.
  task automatic queue_directed();
    queue_pixel(-32768, 0);
    queue_pixel(-1, 255);
    queue_pixel(0, 128);
    queue_pixel(1, 37);
    queue_pixel(32767, 200);
    queue_pixel(2000, 255);
    queue_pixel(400, 0);
    queue_pixel(300, 90);
    queue_pixel(200, 77);
    queue_pixel(133, 255);
    queue_pixel(100, 10);
    queue_pixel(16, 1);
    queue_pixel(1000, 254);
  endtask

  // Half of the requests aim at depths inside the configured range; the rest are invalid,
  // zero or uniformly random disparities.
  task automatic queue_random(int count);
    pixel_req_t px;
    longint unsigned lo, hi, target, dv;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      px.gray = djc_pkg::GRAY_BITS'($urandom);
      if (pick < 15) begin
        px.disparity = DISP_W'($urandom);
        px.disparity[DISP_W-1] = 1'b1;
      end else if (pick < 20) begin
        px.disparity = '0;
      end else if (pick < 50) begin
        px.disparity = DISP_W'($urandom_range(1, (1 << (DISP_W - 1)) - 1));
      end else begin
        lo = cfg_min;
        hi = (cfg_max > cfg_min) ? cfg_max : lo + 1;
        target = lo + $urandom_range(0, int'(hi - lo));
        if (target == 0) target = 1;
        dv = cfg_focal / target;
        if (dv == 0) dv = 1;
        if (dv > (1 << (DISP_W - 1)) - 1) dv = (1 << (DISP_W - 1)) - 1;
        px.disparity = DISP_W'(dv);
      end
      pending_pixels = {pending_pixels, px};
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.disparity = '0;
    in_ch.gray = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_focal = djc_pkg::FOCAL_BASELINE_RESET;
    cfg_min = djc_pkg::MIN_DEPTH_RESET;
    cfg_max = djc_pkg::MAX_DEPTH_RESET;
    cfg_overlay = djc_pkg::OVERLAY_MODE_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: overlay over gray.
    queue_directed();
    drain();

    // Plain colormap with white invalid pixels.
    write_reg(djc_pkg::REG_OVERLAY_MODE, djc_pkg::CFG_DATA_BITS'(0));
    queue_directed();
    queue_random(40);
    drain();

    sender_no_gaps = 1'b1;
    receiver_no_stalls = 1'b1;
    set_config(32'hFFFF_FFFF, 16'd0, 16'hFFFF, 1'b1);
    queue_random(50);
    drain();
    sender_no_gaps = 1'b0;
    receiver_no_stalls = 1'b0;

    // Inverted range with a zero dividend.
    set_config(32'd0, 16'd100, 16'd50, 1'b0);
    queue_pixel(0, 3);
    queue_pixel(5, 250);
    queue_random(30);
    drain();

    // Empty range.
    set_config(32'd123456, 16'd5000, 16'd5000, 1'b1);
    queue_random(30);
    drain();

    set_config(32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_random(20);
    drain();

    // Long result hold while requests keep coming, so the input backs up.
    set_config(32'd1000000, 16'd0, 16'd10000, 1'b1);
    sender_no_gaps = 1'b1;
    queue_random(150);
    long_hold_armed = 1'b1;
    drain();
    sender_no_gaps = 1'b0;

    repeat (3) begin
      set_config($urandom, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
      queue_random(30);
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
